// ----- design/dvt_pkg.sv -----
`default_nettype none

package dvt_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 12;
  localparam int AMB_W    = 12;
  localparam int TEMP_W   = 16;
  localparam int DELTA_W  = 12;
  localparam int GAIN_W   = 16;
  localparam int CAL_W    = 16;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_CAL   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd655;
  localparam logic [CAL_W-1:0]  CAL_NUM_RESET = 16'd293;
  localparam logic [CAL_W-1:0]  CAL_DEN_RESET = 16'd30505;
  localparam logic [CAL_W-1:0]  ZERO_C_CENTIK = 16'd27315;

  // Quotients at or above this value saturate the temperature at the top.
  localparam logic [32:0] SAT_QUOT = 33'd354995;

  // Reciprocal of ten, exact for magnitudes below 2^19.
  localparam int                SCALE_W     = 19;
  localparam logic [SCALE_W-1:0] RECIP_TEN  = 19'd419431;
  localparam int                RECIP_SHIFT = 22;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;

endpackage

`default_nettype wire

// ----- design/diode_delta_v_temperature.sv -----
`default_nettype none

// Two-current diode temperature sensor. Each word carries a low and a high
// bias reading, which pass through separate exponential filters whose gain
// is set by the filter_gain register; read returns the calibrated
// temperature in tenths of a degree, calibrate stores a new ratio from the
// known ambient, and clear zeroes the filters. The block works on one word
// at a time: a read passes through a bit-serial filter multiply of 16
// steps, a bit-serial calibration multiply of 16 steps and a restoring
// divider of ADC_BITS + 16 steps before its result is ready. A calibrate
// ends after the filter update and the delta step, and clear or an unused
// code goes straight to the result. The next word is accepted as soon
// as the result sits in the output register.
module diode_delta_v_temperature #(
  parameter int ADC_BITS  = dvt_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = dvt_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,

  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [dvt_pkg::OP_W-1:0]            in_operation,
  input  wire  [dvt_pkg::SAMPLE_W-1:0]        in_sample_low,
  input  wire  [dvt_pkg::SAMPLE_W-1:0]        in_sample_high,
  input  wire  signed [dvt_pkg::AMB_W-1:0]    in_ambient_tenths,

  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [dvt_pkg::TEMP_W-1:0]   out_temperature_tenths,
  output logic [dvt_pkg::DELTA_W-1:0]         out_delta_reading,
  output logic                                out_cal_error,
  output logic                                out_delta_clamped,

  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [dvt_pkg::GAIN_W-1:0]          cfg_filter_gain
);

  localparam int SB    = ADC_BITS + FRAC_BITS;
  localparam int DIV_W = ADC_BITS + dvt_pkg::CAL_W;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int GW    = dvt_pkg::GAIN_W;
  localparam int CW    = dvt_pkg::CAL_W;
  localparam int TW    = dvt_pkg::TEMP_W;
  localparam int QW    = dvt_pkg::SCALE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILT  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_DELTA = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SCALE = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [GW-1:0]           gain_r, gain_nxt;
  logic [CW-1:0]           cal_num_r, cal_num_nxt;
  logic [CW-1:0]           cal_den_r, cal_den_nxt;
  logic [SB-1:0]           smooth_lo_r, smooth_lo_nxt;
  logic [SB-1:0]           smooth_hi_r, smooth_hi_nxt;

  dvt_pkg::op_t            op_r, op_nxt;
  logic signed [dvt_pkg::AMB_W-1:0] amb_r, amb_nxt;
  logic signed [SB:0]      fdiff_lo_r, fdiff_lo_nxt;
  logic signed [SB:0]      fdiff_hi_r, fdiff_hi_nxt;
  logic signed [SB+1:0]    facc_lo_r, facc_lo_nxt;
  logic signed [SB+1:0]    facc_hi_r, facc_hi_nxt;
  logic [GW-1:0]           gsh_r, gsh_nxt;
  logic [ADC_BITS-1:0]     delta_r, delta_nxt;
  logic [ADC_BITS-1:0]     mhi_r, mhi_nxt;
  logic [CW-1:0]           mlo_r, mlo_nxt;
  logic [DIV_W-1:0]        dq_r, dq_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic                    sat_r, sat_nxt;
  logic                    neg_r, neg_nxt;
  logic [2*QW-1:0]         sprod_r, sprod_nxt;

  logic signed [TW-1:0]    res_temp_r, res_temp_nxt;
  logic                    res_err_r, res_err_nxt;
  logic                    res_clamp_r, res_clamp_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [TW-1:0]    out_temp_r, out_temp_nxt;
  logic [dvt_pkg::DELTA_W-1:0] out_delta_r, out_delta_nxt;
  logic                    out_err_r, out_err_nxt;
  logic                    out_clamp_r, out_clamp_nxt;

  logic                    in_acc;
  logic                    out_load;
  logic [SB-1:0]           tgt_lo, tgt_hi;
  logic signed [SB+1:0]    fsum_lo, fsum_hi;
  logic [ADC_BITS:0]       msum;
  logic [CW:0]             dshift;
  logic [CW+1:0]           dtrial;
  logic [ADC_BITS:0]       vdiff;
  logic [CW-1:0]           amb_ext;
  logic signed [20:0]      xoff;
  logic [20:0]             xmag;
  logic [TW-1:0]           tq;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_delta_reading      = out_delta_r;
  assign out_cal_error          = out_err_r;
  assign out_delta_clamped      = out_clamp_r;

  assign tgt_lo = {ADC_BITS'(in_sample_low), {FRAC_BITS{1'b0}}};
  assign tgt_hi = {ADC_BITS'(in_sample_high), {FRAC_BITS{1'b0}}};

  assign fsum_lo = facc_lo_r + (gsh_r[0] ? {fdiff_lo_r[SB], fdiff_lo_r} : '0);
  assign fsum_hi = facc_hi_r + (gsh_r[0] ? {fdiff_hi_r[SB], fdiff_hi_r} : '0);
  assign msum    = {1'b0, mhi_r} + (mlo_r[0] ? {1'b0, delta_r} : '0);
  assign dshift  = {rem_r, dq_r[DIV_W-1]};
  assign dtrial  = {1'b0, dshift} - {2'b00, cal_num_r};
  assign vdiff   = {1'b0, smooth_hi_r[SB-1:FRAC_BITS]} - {1'b0, smooth_lo_r[SB-1:FRAC_BITS]};
  assign amb_ext = CW'(amb_r);
  assign xoff    = $signed(21'(dq_r)) - $signed({5'd0, dvt_pkg::ZERO_C_CENTIK});
  assign xmag    = xoff[20] ? 21'(-xoff) : 21'(xoff);
  assign tq      = sprod_r[dvt_pkg::RECIP_SHIFT +: TW];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gain_nxt      = gain_r;
    cal_num_nxt   = cal_num_r;
    cal_den_nxt   = cal_den_r;
    smooth_lo_nxt = smooth_lo_r;
    smooth_hi_nxt = smooth_hi_r;
    op_nxt        = op_r;
    amb_nxt       = amb_r;
    fdiff_lo_nxt  = fdiff_lo_r;
    fdiff_hi_nxt  = fdiff_hi_r;
    facc_lo_nxt   = facc_lo_r;
    facc_hi_nxt   = facc_hi_r;
    gsh_nxt       = gsh_r;
    delta_nxt     = delta_r;
    mhi_nxt       = mhi_r;
    mlo_nxt       = mlo_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    sat_nxt       = sat_r;
    neg_nxt       = neg_r;
    sprod_nxt     = sprod_r;
    res_temp_nxt  = res_temp_r;
    res_err_nxt   = res_err_r;
    res_clamp_nxt = res_clamp_r;

    if (cfg_valid && cfg_ready) begin
      gain_nxt = cfg_filter_gain;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_operation;
          amb_nxt       = in_ambient_tenths;
          fdiff_lo_nxt  = $signed({1'b0, tgt_lo}) - $signed({1'b0, smooth_lo_r});
          fdiff_hi_nxt  = $signed({1'b0, tgt_hi}) - $signed({1'b0, smooth_hi_r});
          facc_lo_nxt   = '0;
          facc_hi_nxt   = '0;
          gsh_nxt       = gain_r;
          cnt_nxt       = CNT_W'(GW - 1);
          delta_nxt     = '0;
          res_temp_nxt  = '0;
          res_err_nxt   = 1'b0;
          res_clamp_nxt = 1'b0;
          if (in_operation == dvt_pkg::OP_READ || in_operation == dvt_pkg::OP_CAL) begin
            state_nxt = ST_FILT;
          end else begin
            if (in_operation == dvt_pkg::OP_CLEAR) begin
              smooth_lo_nxt = '0;
              smooth_hi_nxt = '0;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FILT: begin
        facc_lo_nxt = {fsum_lo[SB+1], fsum_lo[SB+1:1]};
        facc_hi_nxt = {fsum_hi[SB+1], fsum_hi[SB+1:1]};
        gsh_nxt     = {1'b0, gsh_r[GW-1:1]};
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        smooth_lo_nxt = smooth_lo_r + facc_lo_r[SB-1:0];
        smooth_hi_nxt = smooth_hi_r + facc_hi_r[SB-1:0];
        state_nxt     = ST_DELTA;
      end
      ST_DELTA: begin
        res_clamp_nxt = vdiff[ADC_BITS];
        delta_nxt     = vdiff[ADC_BITS] ? '0 : vdiff[ADC_BITS-1:0];
        if (op_r == dvt_pkg::OP_CAL) begin
          cal_num_nxt = vdiff[ADC_BITS] ? '0 : CW'(vdiff[ADC_BITS-1:0]);
          cal_den_nxt = (amb_ext << 3) + (amb_ext << 1) + dvt_pkg::ZERO_C_CENTIK;
          res_err_nxt = vdiff[ADC_BITS] || (CW'(vdiff[ADC_BITS-1:0]) == '0);
          state_nxt   = ST_DONE;
        end else if (cal_num_r == '0) begin
          res_err_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          mhi_nxt   = '0;
          mlo_nxt   = cal_den_r;
          cnt_nxt   = CNT_W'(CW - 1);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mhi_nxt = msum[ADC_BITS:1];
        mlo_nxt = {msum[0], mlo_r[CW-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dq_nxt    = {msum[ADC_BITS:1], msum[0], mlo_r[CW-1:1]};
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(DIV_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = dtrial[CW+1] ? dshift[CW-1:0] : dtrial[CW-1:0];
        dq_nxt  = {dq_r[DIV_W-2:0], !dtrial[CW+1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SCALE;
          cnt_nxt   = CNT_W'(1);
        end
      end
      ST_SCALE: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r != '0) begin
          sat_nxt   = (33'(dq_r) >= dvt_pkg::SAT_QUOT);
          neg_nxt   = xoff[20];
          sprod_nxt = xmag[QW-1:0] * dvt_pkg::RECIP_TEN;
        end else begin
          if (sat_r) begin
            res_temp_nxt = dvt_pkg::TEMP_MAX;
          end else begin
            res_temp_nxt = neg_r ? $signed(-tq) : $signed(tq);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_temp_nxt  = out_temp_r;
    out_delta_nxt = out_delta_r;
    out_err_nxt   = out_err_r;
    out_clamp_nxt = out_clamp_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_temp_nxt  = res_temp_r;
      out_delta_nxt = dvt_pkg::DELTA_W'(delta_r);
      out_err_nxt   = res_err_r;
      out_clamp_nxt = res_clamp_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      gain_r      <= dvt_pkg::GAIN_RESET;
      cal_num_r   <= dvt_pkg::CAL_NUM_RESET;
      cal_den_r   <= dvt_pkg::CAL_DEN_RESET;
      smooth_lo_r <= '0;
      smooth_hi_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gain_r      <= gain_nxt;
      cal_num_r   <= cal_num_nxt;
      cal_den_r   <= cal_den_nxt;
      smooth_lo_r <= smooth_lo_nxt;
      smooth_hi_r <= smooth_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    amb_r       <= amb_nxt;
    fdiff_lo_r  <= fdiff_lo_nxt;
    fdiff_hi_r  <= fdiff_hi_nxt;
    facc_lo_r   <= facc_lo_nxt;
    facc_hi_r   <= facc_hi_nxt;
    gsh_r       <= gsh_nxt;
    delta_r     <= delta_nxt;
    mhi_r       <= mhi_nxt;
    mlo_r       <= mlo_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    sat_r       <= sat_nxt;
    neg_r       <= neg_nxt;
    sprod_r     <= sprod_nxt;
    res_temp_r  <= res_temp_nxt;
    res_err_r   <= res_err_nxt;
    res_clamp_r <= res_clamp_nxt;
    out_temp_r  <= out_temp_nxt;
    out_delta_r <= out_delta_nxt;
    out_err_r   <= out_err_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

endmodule

`default_nettype wire
